[rtl/core/dpnd_pkg.sv]
package dpnd_pkg;

    // payload widths
    localparam int SAMPLE_W = 12;
    localparam int THRESH_W = 8;
    localparam int COUNT_W  = 16;
    localparam int NOTE_W   = 7;
    localparam int VALUE_W  = 12;
    localparam int BYTE_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // ring depth default
    localparam int HISTORY_DEPTH_DEF = 32;

    // register reset values
    localparam logic [THRESH_W-1:0] THRESH_RST = 8'd10;
    localparam logic [COUNT_W-1:0]  ON_RST     = 16'd512;
    localparam logic [COUNT_W-1:0]  OFF_RST    = 16'd100;
    localparam logic [NOTE_W-1:0]   NOTE_RST   = 7'd60;

    typedef enum logic [1:0] {
        KIND_NOTE_ON  = 2'd0,
        KIND_NOTE_OFF = 2'd1,
        KIND_DUMP     = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESS_THRESHOLD = 2'd0,
        REG_ON_COUNT        = 2'd1,
        REG_OFF_COUNT       = 2'd2,
        REG_NOTE_NUMBER     = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_COUNT,
        S_TEST,
        S_NOTE_ON,
        S_DUMP_RD,
        S_DUMP,
        S_NOTE_OFF
    } t_state;

endpackage

[rtl/core/dpnd_ifs.sv]
interface dpnd_in_if import dpnd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface dpnd_out_if import dpnd_pkg::*; ();
    logic               valid;
    logic               ready;
    t_kind              event_kind;
    logic [NOTE_W-1:0]  event_note;
    logic [VALUE_W-1:0] event_value;
    logic               last_of_run;

    modport source (output valid, output event_kind, output event_note,
                    output event_value, output last_of_run, input ready);
    modport sink   (input valid, input event_kind, input event_note,
                    input event_value, input last_of_run, output ready);
endinterface

interface dpnd_cfg_if import dpnd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/debounced_pressure_note_detector.sv]
// debounced pressure-pad note detector
//
// i_in carries one 12-bit pad pressure sample per word. o_out carries event
// words: note-on (value = velocity), note-off (value zero) and the ring dump
// bytes that follow a note-on, oldest first; last_of_run marks the final word
// caused by one sample. i_cfg writes the threshold, the on and off counts and
// the note number, indexed in that order; it is always ready.
//
// one sample is handled at a time by a small sequencer around one shared
// 16-bit compare unit: classify against the threshold, count, test against
// the on or off count. a sample giving no event passes the classify and
// count steps, and also the test step when it is tested; a note-off adds
// its emit step; a note-on adds its emit step and, per ring byte, a ram
// read step and an output-load step (fill up to HISTORY_DEPTH).
// an output register parts the sides: the next sample is accepted while the
// last event word still waits. when the receiver stalls, the sequencer holds
// in its emit step and stops taking samples.
//
// reset (synchronous, active low) restores the register defaults, clears the
// counter, the note flag, the ring pointer and fill level; ring bytes beyond
// the fill level are never read, so the ram needs no clearing pass.
module debounced_pressure_note_detector import dpnd_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dpnd_cfg_if.sink    i_cfg,
    dpnd_in_if.sink     i_in,
    dpnd_out_if.source  o_out
);

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam int PW = FW + 1;

    // configuration registers
    logic [THRESH_W-1:0] r_thresh;
    logic [COUNT_W-1:0]  r_on_count;
    logic [COUNT_W-1:0]  r_off_count;
    logic [NOTE_W-1:0]   r_note;

    // control state
    t_state              r_state, n_state;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_sounding, n_sounding;
    logic [AW-1:0]       r_wslot, n_wslot;
    logic [FW-1:0]       r_fill, n_fill;
    logic [FW-1:0]       r_left, n_left;
    logic                r_out_valid, n_out_valid;

    // payload state
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_pressed;
    logic [VALUE_W-1:0]  r_velocity, n_velocity;
    logic [AW-1:0]       r_rd_ptr, n_rd_ptr;
    t_kind               r_out_kind;
    logic [NOTE_W-1:0]   r_out_note;
    logic [VALUE_W-1:0]  r_out_value;
    logic                r_out_last;

    // shared compare unit
    logic [COUNT_W-1:0]  cmp_a, cmp_b;
    logic                cmp_ge;

    // step controls
    logic                in_take;
    logic                out_free;
    logic                out_load;
    t_kind               out_kind;
    logic [VALUE_W-1:0]  out_value;
    logic                out_last;
    logic                ram_wr_en;
    logic                ram_rd_en;
    logic [BYTE_W-1:0]   ram_rd_data;
    logic [COUNT_W-1:0]  count_inc;
    logic [PW-1:0]       ws_ext, fill_ext, start_ext;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_take     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.event_kind  = r_out_kind;
    assign o_out.event_note  = r_out_note;
    assign o_out.event_value = r_out_value;
    assign o_out.last_of_run = r_out_last;

    // one compare serves both the threshold and the count tests
    always_comb begin
        if (r_state == S_CLASSIFY) begin
            cmp_a = COUNT_W'(r_sample);
            cmp_b = COUNT_W'(r_thresh);
        end else begin
            cmp_a = r_count;
            cmp_b = r_sounding ? r_off_count : r_on_count;
        end
    end
    assign cmp_ge = (cmp_a >= cmp_b);

    // saturating counter step
    assign count_inc = (r_count != {COUNT_W{1'b1}}) ? r_count + COUNT_W'(1) : r_count;

    // oldest ring slot: write slot minus fill level, modulo depth
    assign ws_ext   = PW'(r_wslot);
    assign fill_ext = PW'(r_fill);
    assign start_ext = (ws_ext >= fill_ext) ? ws_ext - fill_ext
                                            : ws_ext + PW'(HISTORY_DEPTH) - fill_ext;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_take) n_state = S_CLASSIFY;
            end
            S_CLASSIFY: n_state = S_COUNT;
            S_COUNT: begin
                if (r_pressed != r_sounding) n_state = S_TEST;
                else                         n_state = S_IDLE;
            end
            S_TEST: begin
                if (!cmp_ge)          n_state = S_IDLE;
                else if (r_sounding)  n_state = S_NOTE_OFF;
                else                  n_state = S_NOTE_ON;
            end
            S_NOTE_ON: begin
                if (out_free) n_state = S_DUMP_RD;
            end
            S_DUMP_RD: n_state = S_DUMP;
            S_DUMP: begin
                if (out_free) begin
                    if (r_left == FW'(1)) n_state = S_IDLE;
                    else                  n_state = S_DUMP_RD;
                end
            end
            S_NOTE_OFF: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // step outputs and datapath updates
    always_comb begin
        n_count     = r_count;
        n_sounding  = r_sounding;
        n_velocity  = r_velocity;
        n_wslot     = r_wslot;
        n_fill      = r_fill;
        n_left      = r_left;
        n_rd_ptr    = r_rd_ptr;
        out_load    = 1'b0;
        out_kind    = KIND_DUMP;
        out_value   = '0;
        out_last    = 1'b0;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        case (r_state)
            S_COUNT: begin
                if (r_pressed != r_sounding) begin
                    n_count = count_inc;
                end else begin
                    n_count = '0;
                end
                // ring only records while silent
                if (r_pressed && !r_sounding) begin
                    ram_wr_en = 1'b1;
                    n_wslot   = (r_wslot == AW'(HISTORY_DEPTH - 1)) ? '0
                                                                    : r_wslot + AW'(1);
                    if (r_fill != FW'(HISTORY_DEPTH)) n_fill = r_fill + FW'(1);
                end
            end
            S_TEST: begin
                if (cmp_ge) begin
                    if (r_sounding) begin
                        n_sounding = 1'b0;
                        n_velocity = '0;
                        n_count    = '0;
                    end else begin
                        n_sounding = 1'b1;
                        n_velocity = VALUE_W'(r_sample);
                        n_rd_ptr   = AW'(start_ext);
                        n_left     = r_fill;
                    end
                end
            end
            S_NOTE_ON: begin
                out_load  = out_free;
                out_kind  = KIND_NOTE_ON;
                out_value = r_velocity;
            end
            S_DUMP_RD: begin
                ram_rd_en = 1'b1;
                n_rd_ptr  = (r_rd_ptr == AW'(HISTORY_DEPTH - 1)) ? '0
                                                                 : r_rd_ptr + AW'(1);
            end
            S_DUMP: begin
                out_load  = out_free;
                out_kind  = KIND_DUMP;
                out_value = VALUE_W'(ram_rd_data);
                out_last  = (r_left == FW'(1));
                if (out_free) n_left = r_left - FW'(1);
            end
            S_NOTE_OFF: begin
                out_load  = out_free;
                out_kind  = KIND_NOTE_OFF;
                out_value = '0;
                out_last  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (out_load)          n_out_valid = 1'b1;
        else if (o_out.ready)  n_out_valid = 1'b0;
        else                   n_out_valid = r_out_valid;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sounding  <= 1'b0;
            r_velocity  <= '0;
            r_wslot     <= '0;
            r_fill      <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
            r_thresh    <= THRESH_RST;
            r_on_count  <= ON_RST;
            r_off_count <= OFF_RST;
            r_note      <= NOTE_RST;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sounding  <= n_sounding;
            r_velocity  <= n_velocity;
            r_wslot     <= n_wslot;
            r_fill      <= n_fill;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_reg_idx'(i_cfg.index))
                    REG_PRESS_THRESHOLD: r_thresh    <= i_cfg.data[THRESH_W-1:0];
                    REG_ON_COUNT:        r_on_count  <= i_cfg.data[COUNT_W-1:0];
                    REG_OFF_COUNT:       r_off_count <= i_cfg.data[COUNT_W-1:0];
                    REG_NOTE_NUMBER:     r_note      <= i_cfg.data[NOTE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) r_sample <= i_in.sample;
        if (r_state == S_CLASSIFY) r_pressed <= cmp_ge;
        r_rd_ptr <= n_rd_ptr;
        if (out_load) begin
            r_out_kind  <= out_kind;
            r_out_note  <= r_note;
            r_out_value <= out_value;
            r_out_last  <= out_last;
        end
    end

    // sample history ring
    dpnd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_wslot),
        .i_wr_data (r_sample[BYTE_W-1:0]),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (ram_rd_data)
    );

    // fill level never exceeds the ring
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(HISTORY_DEPTH))
        else $error("ring fill level beyond depth");

    // a note-on word is always followed by at least one dump byte
    a_on_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_NOTE_ON) |-> !r_out_last)
        else $error("note-on marked as last word");

    // dump never runs with nothing left
    a_dump_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP_RD || r_state == S_DUMP) |-> (r_left != '0))
        else $error("dump step with empty count");

    // counter and note flag are cleared when the note-off test passes, before its word is loaded
    a_off_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TEST && cmp_ge && r_sounding) |=> (r_count == '0 && !r_sounding))
        else $error("note-off left counter or flag set");

endmodule

[rtl/core/dpnd_ram.sv]
module dpnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
